FILE: src/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Types and constants of the sensor frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

    localparam logic [7:0]  HDR_FIRST     = 8'h42;
    localparam logic [7:0]  HDR_SECOND    = 8'h4d;
    localparam logic [7:0]  LEN_EXPECT    = 8'h08;
    localparam logic [15:0] SUM_HEADER    = 16'(HDR_FIRST) + 16'(HDR_SECOND);

    localparam logic [3:0]  IDX_AFTER_HDR = 4'd2;
    localparam logic [3:0]  IDX_LEN       = 4'd3;
    localparam logic [3:0]  IDX_PPM_HIGH  = 4'd4;
    localparam logic [3:0]  IDX_PPM_LOW   = 4'd5;
    localparam logic [3:0]  IDX_SUM_HIGH  = 4'd10;
    localparam logic [3:0]  IDX_SUM_LOW   = 4'd11;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'b001,
        PH_GOT42  = 3'b010,
        PH_SYNCED = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        ST_GOOD   = 2'd0,
        ST_BADLEN = 2'd1,
        ST_BADSUM = 2'd2
    } status_t;

    typedef struct packed {
        logic        fires;
        status_t     status;
        logic [15:0] ppm;
    } result_t;

endpackage

`default_nettype wire

FILE: src/sfr_if.sv
// ----------------------------------------------------------------------------
// sfr_if
// Request channels of the sensor frame receiver: received bytes and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_status;
    logic [15:0] co2_ppm;

    modport source (output valid, output frame_status, output co2_ppm, input ready);
    modport sink   (input valid, input frame_status, input co2_ppm, output ready);
endinterface

`default_nettype wire

FILE: src/sfr_parser.sv
// ----------------------------------------------------------------------------
// sfr_parser
// Header hunt, frame collection and length / checksum check, one byte a step.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_parser
    import sfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,
    input  wire logic [7:0] rx_byte,
    output result_t         res
);

    phase_t      phase_reg,    phase_next;
    logic [3:0]  idx_reg,      idx_next;
    logic [15:0] sum_reg,      sum_next;
    logic [7:0]  len_reg,      len_next;
    logic [7:0]  ppm_hi_reg,   ppm_hi_next;
    logic [7:0]  ppm_lo_reg,   ppm_lo_next;
    logic [7:0]  sum_hi_reg,   sum_hi_next;
    logic [15:0] held_reg,     held_next;

    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        sum_next    = sum_reg;
        len_next    = len_reg;
        ppm_hi_next = ppm_hi_reg;
        ppm_lo_next = ppm_lo_reg;
        sum_hi_next = sum_hi_reg;
        held_next   = held_reg;
        res.fires   = 1'b0;
        res.status  = ST_GOOD;
        res.ppm     = held_reg;

        unique case (phase_reg)
            PH_GOT42:
            begin
                if (rx_byte == HDR_SECOND)
                begin
                    phase_next = PH_SYNCED;
                    idx_next   = IDX_AFTER_HDR;
                    sum_next   = SUM_HEADER;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_SYNCED:
            begin
                if (idx_reg < IDX_SUM_HIGH)
                begin
                    if (idx_reg == IDX_LEN)      len_next    = rx_byte;
                    if (idx_reg == IDX_PPM_HIGH) ppm_hi_next = rx_byte;
                    if (idx_reg == IDX_PPM_LOW)  ppm_lo_next = rx_byte;
                    sum_next = sum_reg + 16'(rx_byte);
                    idx_next = idx_reg + 4'd1;
                end
                else if (idx_reg == IDX_SUM_HIGH)
                begin
                    sum_hi_next = rx_byte;
                    idx_next    = IDX_SUM_LOW;
                end
                else
                begin
                    res.fires = 1'b1;
                    priority if (len_reg != LEN_EXPECT)
                    begin
                        res.status = ST_BADLEN;
                    end
                    else if (sum_hi_reg != sum_reg[15:8] || rx_byte != sum_reg[7:0])
                    begin
                        res.status = ST_BADSUM;
                    end
                    else
                    begin
                        res.status = ST_GOOD;
                        held_next  = {ppm_hi_reg, ppm_lo_reg};
                        res.ppm    = {ppm_hi_reg, ppm_lo_reg};
                    end
                    phase_next = PH_HUNT;
                    idx_next   = '0;
                    sum_next   = '0;
                end
            end
            default:
            begin
                phase_next = (rx_byte == HDR_FIRST) ? PH_GOT42 : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            idx_reg    <= '0;
            sum_reg    <= '0;
            len_reg    <= '0;
            ppm_hi_reg <= '0;
            ppm_lo_reg <= '0;
            sum_hi_reg <= '0;
            held_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            sum_reg    <= sum_next;
            len_reg    <= len_next;
            ppm_hi_reg <= ppm_hi_next;
            ppm_lo_reg <= ppm_lo_next;
            sum_hi_reg <= sum_hi_next;
            held_reg   <= held_next;
        end
    end

    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.fires |=> phase_reg == PH_HUNT && idx_reg == '0 && sum_reg == '0)
        else $error("parser did not re-arm after a frame");

    a_fire_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        res.fires |-> phase_reg == PH_SYNCED && idx_reg > IDX_SUM_HIGH)
        else $error("result outside the last frame byte");

    a_good_loads: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.fires && res.status == ST_GOOD |=> held_reg == $past(res.ppm))
        else $error("good frame did not update held ppm");

endmodule

`default_nettype wire

FILE: src/sensor_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// sensor_frame_receiver_top
// Sensor frame receiver: header sync, 12-byte frame check, held CO2 ppm.
// ----------------------------------------------------------------------------
// Takes one received byte per clock cycle unless stalled. Each byte is held in
// an input register and run through the combinational parser; on the last
// byte of a frame, the result lands in the result register. Only the result
// register can stall the input, when a frame ends while the previous result
// still waits to be taken.
`default_nettype none

module sensor_frame_receiver_top
    import sfr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    sfr_byte_if.sink     rx,
    sfr_result_if.source frame
);

    logic        s1_v_reg,     s1_v_next;
    logic [7:0]  s1_byte_reg;
    logic        out_v_reg,    out_v_next;
    logic [1:0]  out_status_reg;
    logic [15:0] out_ppm_reg;

    logic        out_free;
    logic        s1_move;
    logic        rx_take;
    result_t     res;

    sfr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_move),
        .rx_byte (s1_byte_reg),
        .res     (res)
    );

    assign out_free = !out_v_reg || frame.ready;
    assign s1_move  = s1_v_reg && (!res.fires || out_free);
    assign rx.ready = !s1_v_reg || s1_move;
    assign rx_take  = rx.valid && rx.ready;

    always_comb
    begin
        s1_v_next = s1_v_reg;
        if (rx_take)
            s1_v_next = 1'b1;
        else if (s1_move)
            s1_v_next = 1'b0;

        out_v_next = out_v_reg;
        if (s1_move && res.fires)
            out_v_next = 1'b1;
        else if (frame.ready)
            out_v_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg  <= s1_v_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
            s1_byte_reg <= rx.rx_byte;
        if (s1_move && res.fires)
        begin
            out_status_reg <= res.status;
            out_ppm_reg    <= res.ppm;
        end
    end

    assign frame.valid        = out_v_reg;
    assign frame.frame_status = out_status_reg;
    assign frame.co2_ppm      = out_ppm_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_move && res.fires && out_v_reg && !frame.ready))
        else $error("pending result overwritten");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !rx.ready |-> s1_v_reg && res.fires && out_v_reg)
        else $error("input stalled without a pending result");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && !frame.ready |=> out_v_reg && $stable(out_ppm_reg)
            && $stable(out_status_reg))
        else $error("waiting result changed");

endmodule

`default_nettype wire

FILE: sim/tb_sensor_frame_receiver_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sensor_frame_receiver_top
// Self-checking bench for the sensor frame receiver.
// ----------------------------------------------------------------------------
// Feeds received bytes through the byte channel and tracks the parser with a
// behavioral copy of its header sync, frame collection, length and checksum
// checks. Each completed frame queues one expected status and held ppm that
// the result monitor compares against the block. Directed requests cover
// header resync, the maximum ppm and the length-over-checksum precedence;
// random traffic is mostly well-formed frames with random content, mixed with
// bad length bytes, bad checksums, broken headers and noise, under three
// sender/receiver idling profiles.
// ----------------------------------------------------------------------------

module tb_sensor_frame_receiver_top;

    import sfr_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        status_t     status;
        logic [15:0] ppm;
    } frame_result_t;

    logic clk;
    logic rst_n;

    sfr_byte_if   rx_ch ();
    sfr_result_if frame_ch ();

    sensor_frame_receiver_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .frame (frame_ch)
    );

    frame_result_t pending_results[$];
    frame_result_t want;
    int            mismatches;
    int            bytes_sent;
    int            cycle_count;
    int            idle_pct;
    int            stall_pct;

    phase_t        rx_phase;
    logic [3:0]    frame_idx;
    logic [15:0]   sum_acc;
    logic [7:0]    len_byte;
    logic [7:0]    ppm_hi;
    logic [7:0]    ppm_lo;
    logic [7:0]    sum_hi_rx;
    logic [15:0]   ppm_held;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still pending", $time,
                     pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && frame_ch.valid && frame_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual status %0d ppm %04h",
                         $time, frame_ch.frame_status, frame_ch.co2_ppm);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (frame_ch.frame_status !== want.status)
                begin
                    $display("%0t: frame_status expected %0d actual %0d", $time,
                             want.status, frame_ch.frame_status);
                    mismatches++;
                end
                if (frame_ch.co2_ppm !== want.ppm)
                begin
                    $display("%0t: co2_ppm expected %04h actual %04h", $time,
                             want.ppm, frame_ch.co2_ppm);
                    mismatches++;
                end
            end
        end
        frame_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    task automatic clear_parser();
        rx_phase  = PH_HUNT;
        frame_idx = '0;
        sum_acc   = '0;
        len_byte  = '0;
        ppm_hi    = '0;
        ppm_lo    = '0;
        sum_hi_rx = '0;
        ppm_held  = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b);
        frame_result_t res;
        if (rx_phase == PH_GOT42)
        begin
            if (b == HDR_SECOND)
            begin
                rx_phase  = PH_SYNCED;
                frame_idx = IDX_AFTER_HDR;
                sum_acc   = SUM_HEADER;
            end
            else
            begin
                rx_phase = PH_HUNT;
            end
        end
        else if (rx_phase != PH_SYNCED)
        begin
            if (b == HDR_FIRST)
                rx_phase = PH_GOT42;
            else
                rx_phase = PH_HUNT;
        end
        else if (frame_idx < IDX_SUM_HIGH)
        begin
            if (frame_idx == IDX_LEN)
                len_byte = b;
            if (frame_idx == IDX_PPM_HIGH)
                ppm_hi = b;
            if (frame_idx == IDX_PPM_LOW)
                ppm_lo = b;
            sum_acc   = sum_acc + 16'(b);
            frame_idx = frame_idx + 4'd1;
        end
        else if (frame_idx == IDX_SUM_HIGH)
        begin
            sum_hi_rx = b;
            frame_idx = IDX_SUM_LOW;
        end
        else
        begin
            if (len_byte != LEN_EXPECT)
                res.status = ST_BADLEN;
            else if (sum_hi_rx != sum_acc[15:8] || b != sum_acc[7:0])
                res.status = ST_BADSUM;
            else
            begin
                res.status = ST_GOOD;
                ppm_held   = {ppm_hi, ppm_lo};
            end
            res.ppm = ppm_held;
            pending_results.push_back(res);
            rx_phase  = PH_HUNT;
            frame_idx = '0;
            sum_acc   = '0;
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge clk); while (!rx_ch.ready);
        parse_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input bit len_ok, input int sum_err, input logic [15:0] ppm);
        logic [7:0]  fb [12];
        logic [15:0] s;
        fb[0] = HDR_FIRST;
        fb[1] = HDR_SECOND;
        for (int i = 2; i < 10; i++)
            fb[i] = 8'($urandom_range(255));
        fb[IDX_PPM_HIGH] = ppm[15:8];
        fb[IDX_PPM_LOW]  = ppm[7:0];
        if (len_ok)
            fb[IDX_LEN] = LEN_EXPECT;
        else
            do fb[IDX_LEN] = 8'($urandom_range(255)); while (fb[IDX_LEN] == LEN_EXPECT);
        s = '0;
        for (int i = 0; i < 10; i++)
            s = s + 16'(fb[i]);
        fb[IDX_SUM_HIGH] = s[15:8];
        fb[IDX_SUM_LOW]  = s[7:0];
        // corrupt: 1 high byte, 2 low byte, 3 both
        if (sum_err == 1 || sum_err == 3)
            fb[IDX_SUM_HIGH] = fb[IDX_SUM_HIGH] ^ 8'($urandom_range(1, 255));
        if (sum_err == 2 || sum_err == 3)
            fb[IDX_SUM_LOW] = fb[IDX_SUM_LOW] ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < 12; i++)
            push_byte(fb[i]);
    endtask

    task automatic send_noise();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30)
            push_byte(HDR_FIRST);
        else if (pick < 45)
            push_byte(HDR_SECOND);
        else if (pick < 70)
        begin
            push_byte(HDR_FIRST);
            if ($urandom_range(1) == 1)
                push_byte(HDR_FIRST);
            else
                push_byte(8'($urandom_range(255)) & 8'hfe);
        end
        else
            push_byte(8'($urandom_range(255)));
    endtask

    task automatic test_header_resync();
        push_byte(HDR_FIRST);
        push_byte(HDR_FIRST);
        push_byte(HDR_SECOND);
    endtask

    task automatic test_good_frame_max_ppm();
        send_frame(1'b1, 0, 16'hffff);
    endtask

    task automatic test_both_checks_fail();
        send_frame(1'b0, 3, 16'h0000);
    endtask

    task automatic test_random_traffic(input int send_idle, input int recv_stall,
                                       input int n_bytes);
        int stop_at;
        int pick;
        int err;
        logic [15:0] ppm;
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        stop_at   = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(99) < 35)
                repeat ($urandom_range(1, 3)) send_noise();
            pick = $urandom_range(99);
            if (pick < 10)
                ppm = 16'h0000;
            else if (pick < 20)
                ppm = 16'hffff;
            else
                ppm = 16'($urandom_range(65535));
            pick = $urandom_range(99);
            err  = $urandom_range(1, 3);
            if (pick < 55)
                send_frame(1'b1, 0, ppm);
            else if (pick < 70)
                send_frame(1'b0, 0, ppm);
            else if (pick < 88)
                send_frame(1'b1, err, ppm);
            else
                send_frame(1'b0, err, ppm);
        end
    endtask

    initial
    begin
        mismatches     = 0;
        bytes_sent     = 0;
        cycle_count    = 0;
        idle_pct       = 27;
        stall_pct      = 69;
        clear_parser();
        rst_n          = 1'b0;
        rx_ch.valid    <= 1'b0;
        rx_ch.rx_byte  <= 8'h00;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header_resync();
        test_good_frame_max_ppm();
        test_both_checks_fail();
        test_random_traffic(27, 69, 550);
        test_random_traffic(69, 27, 550);
        test_random_traffic(0, 0, 550);

        rx_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
